### design/color_sensor_period_classifier_top_macros.svh
// Assertion macros shared by the checker of the colour sensor classifier.
`ifndef COLOR_SENSOR_PERIOD_CLASSIFIER_TOP_MACROS_SVH
`define COLOR_SENSOR_PERIOD_CLASSIFIER_TOP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define CSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("colour sensor classifier check failed");

// Condition implies consequence in the following cycle.
`define CSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("colour sensor classifier check failed");

`endif

### design/csp_pkg.sv
// Types, constants and register map of the colour sensor classifier.
package csp_pkg;

    localparam int CSP_PERIOD_BITS = 20;
    localparam int CSP_VALUE_W     = 14;
    localparam int CSP_BIT_CNT_W   = 4;
    localparam logic [CSP_VALUE_W-1:0] CSP_DIVIDEND = 14'd10000;

    localparam int CSP_ADDR_W = 3;
    localparam int CSP_DATA_W = 32;

    localparam logic REG_DARK   = 1'b0;
    localparam logic REG_ORANGE = 1'b1;

    localparam logic [CSP_VALUE_W-1:0] CSP_DARK_RESET   = 14'd95;
    localparam logic [CSP_VALUE_W-1:0] CSP_ORANGE_RESET = 14'd110;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_BLUE  = 2'd1;
    localparam logic [1:0] CH_GREEN = 2'd2;
    localparam logic [1:0] CH_CLEAR = 2'd3;

    localparam logic [2:0] COLOR_NONE   = 3'd0;
    localparam logic [2:0] COLOR_ORANGE = 3'd1;
    localparam logic [2:0] COLOR_RED    = 3'd2;
    localparam logic [2:0] COLOR_GREEN  = 3'd3;
    localparam logic [2:0] COLOR_BLUE   = 3'd4;
    localparam logic [2:0] COLOR_YELLOW = 3'd5;

    typedef enum logic [1:0] {
        PH_WAIT_LOW  = 2'd0,
        PH_WAIT_HIGH = 2'd1,
        PH_CNT_LOW   = 2'd2,
        PH_CNT_HIGH  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

### design/csp_if.sv
// Valid/ready channel interfaces for sensor samples and classifier results.
interface csp_in_if;
    logic valid;
    logic ready;
    logic sensor_level;

    modport source (output valid, output sensor_level, input ready);
    modport sink   (input valid, input sensor_level, output ready);
endinterface

interface csp_out_if;
    logic       valid;
    logic       ready;
    logic       filter_s2;
    logic       filter_s3;
    logic       scale_s0;
    logic       scale_s1;
    logic       color_valid;
    logic [2:0] color_code;

    modport source (output valid, output filter_s2, output filter_s3, output scale_s0,
                    output scale_s1, output color_valid, output color_code, input ready);
    modport sink   (input valid, input filter_s2, input filter_s3, input scale_s0,
                    input scale_s1, input color_valid, input color_code, output ready);
endinterface

### design/color_sensor_period_classifier_top.sv
// Colour sensor classifier: one sensor sample word in per microsecond tick, one result word out
// per sample. The block steps the filter through red, blue, green and clear, times one full
// pulse period per filter and turns it into floor(10000/period) with a shared serial divider;
// after the clear channel it classifies the four values. A sample that does not close a period
// is answered in the next cycle. A sample that closes a period is accepted; the divider then
// forms the value (one quotient bit per cycle), which is stored and emitted. The block takes
// no new word while that work runs or while an unread result blocks the output register.
module color_sensor_period_classifier_top
    import csp_pkg::*;
#(
    parameter int PERIOD_BITS = CSP_PERIOD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csp_in_if.sink                i_in,
    csp_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CSP_ADDR_W-1:0] paddr,
    input  logic [CSP_DATA_W-1:0] pwdata,
    output logic [CSP_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [1:0]             r_chan, n_chan;
    logic [PERIOD_BITS-1:0] r_count, n_count;
    logic [PERIOD_BITS-1:0] count_inc;
    logic [CSP_VALUE_W-1:0] r_dark;
    logic [CSP_VALUE_W-1:0] r_orange;
    logic [CSP_VALUE_W-1:0] r_values [4];

    logic       r_out_valid, n_out_valid;
    logic       r_s2, n_s2;
    logic       r_s3, n_s3;
    logic       r_cvalid, n_cvalid;
    logic [2:0] r_code, n_code;

    logic                   accept;
    logic                   slot_free;
    logic                   div_start;
    logic                   div_done;
    logic [CSP_VALUE_W-1:0] div_quot;
    logic                   cls_hit;
    logic [2:0]             cls_code;

    csp_div #(.PERIOD_BITS(PERIOD_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_period (count_inc),
        .o_done   (div_done),
        .o_quot   (div_quot)
    );

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark   <= CSP_DARK_RESET;
            r_orange <= CSP_ORANGE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DARK:   r_dark   <= pwdata[CSP_VALUE_W-1:0];
                REG_ORANGE: r_orange <= pwdata[CSP_VALUE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DARK:   prdata = {{(CSP_DATA_W-CSP_VALUE_W){1'b0}}, r_dark};
            REG_ORANGE: prdata = {{(CSP_DATA_W-CSP_VALUE_W){1'b0}}, r_orange};
            default:    prdata = '0;
        endcase
    end

    // Classification of the four stored channel values.
    always_comb begin
        logic [CSP_VALUE_W-1:0] vr, vb, vg, vn;
        vr = r_values[CH_RED];
        vb = r_values[CH_BLUE];
        vg = r_values[CH_GREEN];
        vn = r_values[CH_CLEAR];
        cls_hit  = 1'b1;
        cls_code = COLOR_NONE;
        priority if (vn < r_dark) begin
            cls_code = COLOR_NONE;
        end else if (vr > vg && vr > vb && vb > vg) begin
            cls_code = (vn > r_orange) ? COLOR_ORANGE : COLOR_RED;
        end else if (vg > vr && vg > vb && vb > vr) begin
            cls_code = COLOR_GREEN;
        end else if (vb > vr && vb > vg && vg > vr) begin
            cls_code = COLOR_BLUE;
        end else if (vr > vg && vr > vb && vg > vb) begin
            cls_code = COLOR_YELLOW;
        end else begin
            cls_hit = 1'b0;
        end
    end

    assign slot_free   = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && slot_free;
    assign accept      = i_in.valid && i_in.ready;
    assign count_inc   = ((r_phase == PH_CNT_LOW || r_phase == PH_CNT_HIGH) && r_count != '1)
                         ? r_count + 1'b1 : r_count;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_chan      = r_chan;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_cvalid    = r_cvalid;
        n_code      = r_code;
        div_start   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_count     = count_inc;
                    n_out_valid = 1'b1;
                    n_cvalid    = 1'b0;
                    n_code      = COLOR_NONE;
                    unique case (r_phase)
                        PH_WAIT_LOW: begin
                            if (!i_in.sensor_level) n_phase = PH_WAIT_HIGH;
                        end
                        PH_WAIT_HIGH: begin
                            if (i_in.sensor_level) begin
                                n_phase = PH_CNT_LOW;
                                n_count = '0;
                            end
                        end
                        PH_CNT_LOW: begin
                            if (!i_in.sensor_level) n_phase = PH_CNT_HIGH;
                        end
                        PH_CNT_HIGH: begin
                            if (i_in.sensor_level) begin
                                // Period closed: the result word waits for the divider.
                                n_phase     = PH_WAIT_LOW;
                                n_count     = '0;
                                n_out_valid = 1'b0;
                                div_start   = 1'b1;
                                n_state     = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                    n_s2 = n_chan[1];
                    n_s3 = n_chan[1] ^ n_chan[0];
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_cvalid    = 1'b0;
                    n_code      = COLOR_NONE;
                    if (r_chan == CH_CLEAR) begin
                        n_chan   = CH_RED;
                        n_cvalid = cls_hit;
                        n_code   = cls_hit ? cls_code : COLOR_NONE;
                    end else begin
                        n_chan = r_chan + 1'b1;
                    end
                    n_s2    = n_chan[1];
                    n_s3    = n_chan[1] ^ n_chan[0];
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_WAIT_LOW;
            r_chan      <= CH_RED;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_chan      <= n_chan;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2     <= n_s2;
        r_s3     <= n_s3;
        r_cvalid <= n_cvalid;
        r_code   <= n_code;
        if (r_state == ST_DIV && div_done) r_values[r_chan] <= div_quot;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.filter_s2   = r_s2;
    assign o_out.filter_s3   = r_s3;
    assign o_out.scale_s0    = 1'b1;
    assign o_out.scale_s1    = 1'b0;
    assign o_out.color_valid = r_cvalid;
    assign o_out.color_code  = r_code;

endmodule

### design/csp_div.sv
// Restoring shift-subtract divider: 10000 / period, one quotient bit a cycle.
module csp_div
    import csp_pkg::*;
#(
    parameter int PERIOD_BITS = CSP_PERIOD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PERIOD_BITS-1:0] i_period,
    output logic                   o_done,
    output logic [CSP_VALUE_W-1:0] o_quot
);

    logic                     r_run;
    logic                     r_done;
    logic                     r_zero;
    logic [CSP_BIT_CNT_W-1:0] r_bit;
    logic [PERIOD_BITS-1:0]   r_rem;
    logic [PERIOD_BITS-1:0]   r_div;
    logic [CSP_VALUE_W-1:0]   r_quo;
    logic [PERIOD_BITS:0]     trial;
    logic [PERIOD_BITS:0]     diff;
    logic                     q_bit;

    assign trial = {r_rem, CSP_DIVIDEND[r_bit]};
    assign diff  = trial - {1'b0, r_div};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_bit == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit  <= CSP_BIT_CNT_W'(CSP_VALUE_W - 1);
            r_rem  <= '0;
            r_quo  <= '0;
            r_div  <= i_period;
            // A zero period or a saturated count reads as no signal.
            r_zero <= (i_period == '0) || (i_period == '1);
        end else if (r_run) begin
            r_bit <= r_bit - 1'b1;
            r_quo <= {r_quo[CSP_VALUE_W-2:0], q_bit};
            r_rem <= q_bit ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quo;

endmodule

### design/csp_checker.sv
// Port-level checks for the colour sensor classifier, bound to its top level.
`include "color_sensor_period_classifier_top_macros.svh"

module csp_checker
    import csp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_filter_s2,
    input logic       i_filter_s3,
    input logic       i_scale_s0,
    input logic       i_scale_s1,
    input logic       i_color_valid,
    input logic [2:0] i_color_code
);

    // A pending unread result word must block new samples.
    `CSP_ASSERT_NOW(a_stall_blocks_input, i_out_valid && !i_out_ready, !i_in_ready)
    `CSP_ASSERT_NOW(a_scale_fixed, i_out_valid, i_scale_s0 && !i_scale_s1)
    `CSP_ASSERT_NOW(a_code_only_when_valid, i_out_valid && !i_color_valid, i_color_code == COLOR_NONE)
    // A classification always restarts with the red filter.
    `CSP_ASSERT_NOW(a_restart_red, i_out_valid && i_color_valid, !i_filter_s2 && !i_filter_s3)
    `CSP_ASSERT_NEXT(a_result_held, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind color_sensor_period_classifier_top csp_checker u_csp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_filter_s2   (o_out.filter_s2),
    .i_filter_s3   (o_out.filter_s3),
    .i_scale_s0    (o_out.scale_s0),
    .i_scale_s1    (o_out.scale_s1),
    .i_color_valid (o_out.color_valid),
    .i_color_code  (o_out.color_code)
);
